### rtl/sbr_pkg.sv
// ----------------------------------------------------------------------------
// Stream byte reassembler package
// Shared constants and the request type that travels from the front end
// through the request queue to the back end.
// ----------------------------------------------------------------------------
package sbr_pkg;

    localparam int unsigned CAPACITY_DEFAULT = 64;
    localparam int unsigned QUEUE_DEPTH      = 2;
    localparam int unsigned BYTE_W           = 8;
    localparam int unsigned INDEX_W          = 32;
    localparam int unsigned ROOM_W           = 7;

    typedef struct packed {
        logic [BYTE_W-1:0]  value;
        logic [INDEX_W-1:0] index;
        logic               has;
        logic               seg_end;
        logic               eof;
        logic [ROOM_W-1:0]  room;
        logic [INDEX_W-1:0] eof_pos;
    } sbr_req_t;

endpackage

### rtl/sbr_front.sv
// ----------------------------------------------------------------------------
// Front end
// Accepts input requests, saturates the room to the buffer size and works out
// the end-of-stream position, then hands the request on to the queue.
// ----------------------------------------------------------------------------
module sbr_front
    import sbr_pkg::*;
#(
    parameter int unsigned CAPACITY = CAPACITY_DEFAULT
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic [BYTE_W-1:0]  byte_value,
    input  logic [INDEX_W-1:0] byte_index,
    input  logic               has_byte,
    input  logic               segment_end,
    input  logic               eof_mark,
    input  logic [ROOM_W-1:0]  room,
    input  logic               in_valid,
    output logic               in_ready,
    output sbr_req_t           req,
    output logic               req_valid,
    input  logic               req_ready
);

    localparam int unsigned ROOM_CAP = (CAPACITY < 127) ? CAPACITY : 127;
    localparam logic [ROOM_W-1:0] ROOM_MAX = ROOM_W'(ROOM_CAP);

    logic     hold_v_reg;
    logic     hold_v_next;
    sbr_req_t hold_reg;
    sbr_req_t hold_next;
    logic     accept;

    assign in_ready  = !hold_v_reg || req_ready;
    assign accept    = in_valid && in_ready;
    assign req       = hold_reg;
    assign req_valid = hold_v_reg;

    always_comb
    begin
        hold_next.value   = byte_value;
        hold_next.index   = byte_index;
        hold_next.has     = has_byte;
        hold_next.seg_end = segment_end;
        hold_next.eof     = eof_mark;
        hold_next.room    = (room > ROOM_MAX) ? ROOM_MAX : room;
        hold_next.eof_pos = byte_index + INDEX_W'(has_byte);

        if (accept)
        begin
            hold_v_next = 1'b1;
        end
        else if (req_ready)
        begin
            hold_v_next = 1'b0;
        end
        else
        begin
            hold_v_next = hold_v_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_v_reg <= 1'b0;
        end
        else
        begin
            hold_v_reg <= hold_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            hold_reg <= hold_next;
        end
    end

endmodule

### rtl/sbr_queue.sv
// ----------------------------------------------------------------------------
// Request queue
// Short first-in first-out queue that decouples the front end from the
// back end.
// ----------------------------------------------------------------------------
module sbr_queue
    import sbr_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  sbr_req_t push_req,
    input  logic     push_valid,
    output logic     push_ready,
    output sbr_req_t pop_req,
    output logic     pop_valid,
    input  logic     pop_ready
);

    localparam int unsigned QAW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned QCW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [QAW-1:0] LAST_ENTRY = QAW'(QUEUE_DEPTH - 1);
    localparam logic [QCW-1:0] FULL_COUNT = QCW'(QUEUE_DEPTH);

    sbr_req_t       q_mem [QUEUE_DEPTH];
    logic [QAW-1:0] wr_ptr_reg;
    logic [QAW-1:0] wr_ptr_next;
    logic [QAW-1:0] rd_ptr_reg;
    logic [QAW-1:0] rd_ptr_next;
    logic [QCW-1:0] count_reg;
    logic [QCW-1:0] count_next;
    logic           do_push;
    logic           do_pop;

    assign push_ready = (count_reg != FULL_COUNT);
    assign pop_valid  = (count_reg != '0);
    assign pop_req    = q_mem[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_ENTRY) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_ENTRY) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            q_mem[wr_ptr_reg] <= push_req;
        end
    end

endmodule

### rtl/sbr_back.sv
// ----------------------------------------------------------------------------
// Back end
// Owns the ring buffer (filled flag and byte per slot), the window check,
// the end-of-stream record and the drain sequencer with its output register.
// ----------------------------------------------------------------------------
module sbr_back
    import sbr_pkg::*;
#(
    parameter int unsigned CAPACITY = CAPACITY_DEFAULT
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  sbr_req_t          req,
    input  logic              req_valid,
    output logic              req_ready,
    output logic [BYTE_W-1:0] out_byte,
    output logic              out_valid,
    output logic              run_last,
    output logic              stream_end,
    output logic [ROOM_W-1:0] pending_count,
    output logic              none_pending,
    output logic              res_valid,
    input  logic              res_ready
);

    localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int unsigned CW = $clog2(CAPACITY + 1);
    localparam logic [AW-1:0] LAST_SLOT = AW'(CAPACITY - 1);
    localparam logic [AW:0]   CAP_SUM   = (AW + 1)'(CAPACITY);
    localparam logic [CW-1:0] CAP_CNT   = CW'(CAPACITY);

    typedef enum logic [9:0] {
        ST_CLEAR      = 10'b00_0000_0001,
        ST_IDLE       = 10'b00_0000_0010,
        ST_CALC       = 10'b00_0000_0100,
        ST_WRITE      = 10'b00_0000_1000,
        ST_SCAN_START = 10'b00_0001_0000,
        ST_SCAN       = 10'b00_0010_0000,
        ST_PREP       = 10'b00_0100_0000,
        ST_EMIT_RD    = 10'b00_1000_0000,
        ST_EMIT_OUT   = 10'b01_0000_0000,
        ST_FLAGS      = 10'b10_0000_0000
    } state_t;

    function automatic logic [AW-1:0] slot_inc(input logic [AW-1:0] p);
        return (p == LAST_SLOT) ? '0 : p + 1'b1;
    endfunction

    // Each slot holds its filled flag above the data byte.
    logic [BYTE_W:0]     slot_mem [CAPACITY];
    logic [BYTE_W:0]     rd_data_reg;
    logic                mem_re;
    logic [AW-1:0]       mem_ra;
    logic                mem_we;
    logic [AW-1:0]       mem_wa;
    logic [BYTE_W:0]     mem_wd;

    state_t              state_reg;
    state_t              state_next;
    sbr_req_t            req_reg;
    sbr_req_t            req_next;
    logic                in_win_reg;
    logic                in_win_next;
    logic [AW-1:0]       offset_reg;
    logic [AW-1:0]       offset_next;
    logic [AW-1:0]       slot_reg;
    logic [AW-1:0]       slot_next;
    logic [INDEX_W-1:0]  next_exp_reg;
    logic [INDEX_W-1:0]  next_exp_next;
    logic [AW-1:0]       head_reg;
    logic [AW-1:0]       head_next;
    logic [CW-1:0]       pend_reg;
    logic [CW-1:0]       pend_next;
    logic                eof_seen_reg;
    logic                eof_seen_next;
    logic [INDEX_W-1:0]  eof_pos_reg;
    logic [INDEX_W-1:0]  eof_pos_next;
    logic [AW-1:0]       ptr_reg;
    logic [AW-1:0]       ptr_next;
    logic [CW-1:0]       cnt_reg;
    logic [CW-1:0]       cnt_next;
    logic                fin_reg;
    logic                fin_next;
    logic [CW-1:0]       pfin_reg;
    logic [CW-1:0]       pfin_next;

    logic                res_v_reg;
    logic                res_v_next;
    logic [BYTE_W-1:0]   obyte_reg;
    logic [BYTE_W-1:0]   obyte_next;
    logic                ovalid_reg;
    logic                ovalid_next;
    logic                olast_reg;
    logic                olast_next;
    logic                oend_reg;
    logic                oend_next;
    logic [CW-1:0]       opend_reg;
    logic [CW-1:0]       opend_next;
    logic                out_load;
    logic                out_free;

    logic [INDEX_W:0]    diff;
    logic                in_win;
    logic [AW:0]         slot_sum;
    logic [AW-1:0]       slot_calc;

    assign out_free = !res_v_reg || res_ready;

    // Window check: the offset from the next expected index must be below the room.
    assign diff   = {1'b0, req.index} - {1'b0, next_exp_reg};
    assign in_win = req.has && !diff[INDEX_W]
                    && (diff[INDEX_W-1:0] < INDEX_W'(req.room));

    assign slot_sum  = {1'b0, head_reg} + {1'b0, offset_reg};
    assign slot_calc = (slot_sum >= CAP_SUM) ? AW'(slot_sum - CAP_SUM) : slot_sum[AW-1:0];

    always_comb
    begin
        state_next    = state_reg;
        req_next      = req_reg;
        in_win_next   = in_win_reg;
        offset_next   = offset_reg;
        slot_next     = slot_reg;
        next_exp_next = next_exp_reg;
        head_next     = head_reg;
        pend_next     = pend_reg;
        eof_seen_next = eof_seen_reg;
        eof_pos_next  = eof_pos_reg;
        ptr_next      = ptr_reg;
        cnt_next      = cnt_reg;
        fin_next      = fin_reg;
        pfin_next     = pfin_reg;
        req_ready     = 1'b0;
        mem_re        = 1'b0;
        mem_ra        = head_reg;
        mem_we        = 1'b0;
        mem_wa        = head_reg;
        mem_wd        = '0;
        out_load      = 1'b0;
        obyte_next    = '0;
        ovalid_next   = 1'b0;
        olast_next    = 1'b1;

        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_we   = 1'b1;
                mem_wa   = ptr_reg;
                ptr_next = slot_inc(ptr_reg);
                if (ptr_reg == LAST_SLOT)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    req_next    = req;
                    in_win_next = in_win;
                    offset_next = diff[AW-1:0];
                    if (req.eof)
                    begin
                        eof_seen_next = 1'b1;
                        eof_pos_next  = req.eof_pos;
                    end
                    state_next = ST_CALC;
                end
            end
            ST_CALC:
            begin
                slot_next = slot_calc;
                mem_re    = 1'b1;
                mem_ra    = slot_calc;
                if (in_win_reg)
                begin
                    state_next = ST_WRITE;
                end
                else if (req_reg.seg_end)
                begin
                    state_next = ST_SCAN_START;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_WRITE:
            begin
                // Later copies of a byte never overwrite a filled slot.
                if (!rd_data_reg[BYTE_W])
                begin
                    mem_we    = 1'b1;
                    mem_wa    = slot_reg;
                    mem_wd    = {1'b1, req_reg.value};
                    pend_next = pend_reg + 1'b1;
                end
                state_next = req_reg.seg_end ? ST_SCAN_START : ST_IDLE;
            end
            ST_SCAN_START:
            begin
                mem_re     = 1'b1;
                mem_ra     = head_reg;
                ptr_next   = head_reg;
                cnt_next   = '0;
                state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                // The next slot is read ahead while the current one is checked.
                mem_re = 1'b1;
                mem_ra = slot_inc(ptr_reg);
                if (rd_data_reg[BYTE_W])
                begin
                    cnt_next = cnt_reg + 1'b1;
                    ptr_next = slot_inc(ptr_reg);
                    if (cnt_reg + 1'b1 == CAP_CNT)
                    begin
                        state_next = ST_PREP;
                    end
                end
                else
                begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP:
            begin
                pfin_next  = pend_reg - cnt_reg;
                fin_next   = eof_seen_reg
                             && ((next_exp_reg + INDEX_W'(cnt_reg)) == eof_pos_reg);
                state_next = (cnt_reg == '0) ? ST_FLAGS : ST_EMIT_RD;
            end
            ST_EMIT_RD:
            begin
                mem_re     = 1'b1;
                mem_ra     = head_reg;
                state_next = ST_EMIT_OUT;
            end
            ST_EMIT_OUT:
            begin
                if (out_free)
                begin
                    out_load      = 1'b1;
                    obyte_next    = rd_data_reg[BYTE_W-1:0];
                    ovalid_next   = 1'b1;
                    olast_next    = (cnt_reg == CW'(1));
                    mem_we        = 1'b1;
                    mem_wa        = head_reg;
                    head_next     = slot_inc(head_reg);
                    next_exp_next = next_exp_reg + 1'b1;
                    pend_next     = pend_reg - 1'b1;
                    cnt_next      = cnt_reg - 1'b1;
                    state_next    = (cnt_reg == CW'(1)) ? ST_IDLE : ST_EMIT_RD;
                end
            end
            ST_FLAGS:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (out_load)
        begin
            res_v_next = 1'b1;
        end
        else if (res_ready)
        begin
            res_v_next = 1'b0;
        end
        else
        begin
            res_v_next = res_v_reg;
        end
        oend_next  = fin_reg;
        opend_next = pfin_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            next_exp_reg <= '0;
            head_reg     <= '0;
            pend_reg     <= '0;
            eof_seen_reg <= 1'b0;
            eof_pos_reg  <= '0;
            ptr_reg      <= '0;
            cnt_reg      <= '0;
            fin_reg      <= 1'b0;
            pfin_reg     <= '0;
            res_v_reg    <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            next_exp_reg <= next_exp_next;
            head_reg     <= head_next;
            pend_reg     <= pend_next;
            eof_seen_reg <= eof_seen_next;
            eof_pos_reg  <= eof_pos_next;
            ptr_reg      <= ptr_next;
            cnt_reg      <= cnt_next;
            fin_reg      <= fin_next;
            pfin_reg     <= pfin_next;
            res_v_reg    <= res_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg    <= req_next;
        in_win_reg <= in_win_next;
        offset_reg <= offset_next;
        slot_reg   <= slot_next;
        if (out_load)
        begin
            obyte_reg  <= obyte_next;
            ovalid_reg <= ovalid_next;
            olast_reg  <= olast_next;
            oend_reg   <= oend_next;
            opend_reg  <= opend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            slot_mem[mem_wa] <= mem_wd;
        end
        if (mem_re)
        begin
            rd_data_reg <= slot_mem[mem_ra];
        end
    end

    assign res_valid     = res_v_reg;
    assign out_byte      = obyte_reg;
    assign out_valid     = ovalid_reg;
    assign run_last      = olast_reg;
    assign stream_end    = oend_reg;
    assign pending_count = ROOM_W'(opend_reg);
    assign none_pending  = (opend_reg == '0);

endmodule

### rtl/stream_byte_reassembler_unit.sv
// ----------------------------------------------------------------------------
// Stream byte reassembler
// Puts out-of-order segment bytes back in stream order through a ring buffer.
// ----------------------------------------------------------------------------
// Input requests (in_valid/in_ready) carry an optional byte with its stream index,
// the downstream room and the segment-end and end-of-stream marks. Result
// requests (res_valid/res_ready) carry the assembled bytes of a drain with
// the end-of-stream, last-of-run and pending-count flags.
// A request that is not a segment end produces no result. A segment end
// produces one result per drained byte, or a single flag-only result.
// Requests pass a front register and a two-entry queue before the back end,
// which checks each request against the window and, for a byte that falls
// in it, reads and then writes its slot; any other request is checked and
// has its slot read. A segment end then scans the run of filled slots in
// the single-port ring buffer and drains them, reading and then emitting
// each byte in turn. After reset the back end clears the filled flags of
// all CAPACITY slots, one per cycle, before it takes the first queued
// request; the front keeps accepting until the queue fills. A stalled
// receiver holds the result in the output register and the drain waits;
// the queue and front then fill and in_ready drops.
// ----------------------------------------------------------------------------
module stream_byte_reassembler_unit
    import sbr_pkg::*;
#(
    parameter int unsigned CAPACITY = CAPACITY_DEFAULT
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic [BYTE_W-1:0]  byte_value,
    input  logic [INDEX_W-1:0] byte_index,
    input  logic               has_byte,
    input  logic               segment_end,
    input  logic               eof_mark,
    input  logic [ROOM_W-1:0]  room,
    input  logic               in_valid,
    output logic               in_ready,
    output logic [BYTE_W-1:0]  out_byte,
    output logic               out_valid,
    output logic               run_last,
    output logic               stream_end,
    output logic [ROOM_W-1:0]  pending_count,
    output logic               none_pending,
    output logic               res_valid,
    input  logic               res_ready
);

    sbr_req_t front_req;
    logic     front_valid;
    logic     front_ready;
    sbr_req_t back_req;
    logic     back_valid;
    logic     back_ready;

    sbr_front #(
        .CAPACITY (CAPACITY)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .byte_value  (byte_value),
        .byte_index  (byte_index),
        .has_byte    (has_byte),
        .segment_end (segment_end),
        .eof_mark    (eof_mark),
        .room        (room),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .req         (front_req),
        .req_valid   (front_valid),
        .req_ready   (front_ready)
    );

    sbr_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_req   (front_req),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .pop_req    (back_req),
        .pop_valid  (back_valid),
        .pop_ready  (back_ready)
    );

    sbr_back #(
        .CAPACITY (CAPACITY)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .req           (back_req),
        .req_valid     (back_valid),
        .req_ready     (back_ready),
        .out_byte      (out_byte),
        .out_valid     (out_valid),
        .run_last      (run_last),
        .stream_end    (stream_end),
        .pending_count (pending_count),
        .none_pending  (none_pending),
        .res_valid     (res_valid),
        .res_ready     (res_ready)
    );

endmodule
